/* src/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg: shared types and helpers for the top-K target selector
// Record and item layouts, command codes and the record ordering function.
// ----------------------------------------------------------------------------
package tks_pkg;

    // default store depth
    localparam int MAX_KEEP_DEF = 32;
    // max_targets register
    localparam int          CFG_W     = 6;
    localparam logic [5:0]  CFG_RESET = 6'd32;

    // command codes
    localparam logic [1:0] CMD_CONSIDER = 2'd0;
    localparam logic [1:0] CMD_FINISH   = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_SPARE    = 2'd3;

    typedef struct packed {
        logic        [15:0] conf;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [30:0] w;
        logic        [30:0] h;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic        [31:0] id;
    } t_rec;

    typedef struct packed {
        logic [1:0] cmd;
        t_rec       rec;
    } t_item;

    // true when a is strictly better than b
    function automatic logic outranks(t_rec a, t_rec b);
        if (a.conf != b.conf) return a.conf > b.conf;
        if (a.y != b.y) return $signed(a.y) < $signed(b.y);
        if (a.x != b.x) return $signed(a.x) < $signed(b.x);
        return a.id < b.id;
    endfunction

endpackage

/* src/tks_if.sv */
// ----------------------------------------------------------------------------
// tks_if: channel interfaces of the top-K target selector
// Item input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tks_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic        [15:0] confidence;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [30:0] box_width;
    logic        [30:0] box_height;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic        [31:0] ident;

    modport source (output valid, cmd, confidence, pos_x, pos_y, box_width, box_height,
                    aim_x, aim_y, ident, input ready);
    modport sink   (input valid, cmd, confidence, pos_x, pos_y, box_width, box_height,
                    aim_x, aim_y, ident, output ready);
endinterface

interface tks_res_if;
    logic               valid;
    logic               ready;
    logic        [15:0] out_confidence;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic        [30:0] out_width;
    logic        [30:0] out_height;
    logic signed [31:0] out_aim_x;
    logic signed [31:0] out_aim_y;
    logic        [31:0] out_ident;
    logic        [4:0]  rank;
    logic               last;
    logic               empty_res;

    modport source (output valid, out_confidence, out_x, out_y, out_width, out_height,
                    out_aim_x, out_aim_y, out_ident, rank, last, empty_res, input ready);
    modport sink   (input valid, out_confidence, out_x, out_y, out_width, out_height,
                    out_aim_x, out_aim_y, out_ident, rank, last, empty_res, output ready);
endinterface

/* src/tks_front.sv */
// ----------------------------------------------------------------------------
// tks_front: item intake and command queue
// Takes item transfers, drops unused commands, queues the rest two deep.
// ----------------------------------------------------------------------------
module tks_front
    import tks_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tks_item_if.sink i_item,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_ready
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_item      in_item;

    assign i_item.ready = (r_cnt != 2'd2);
    assign in_item = '{cmd: i_item.cmd,
                       rec: '{conf: i_item.confidence, x: i_item.pos_x, y: i_item.pos_y,
                              w: i_item.box_width, h: i_item.box_height,
                              ax: i_item.aim_x, ay: i_item.aim_y, id: i_item.ident}};

    // unused command code is accepted but never queued
    assign push = i_item.valid && i_item.ready &&
                  (i_item.cmd == CMD_CONSIDER || i_item.cmd == CMD_FINISH ||
                   i_item.cmd == CMD_CLEAR);
    assign pop  = o_q_valid && i_q_ready;

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= in_item;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* src/tks_back.sv */
// ----------------------------------------------------------------------------
// tks_back: heap engine and result register
// Min-heap of held records in a one-read one-write memory; sift up/down,
// in-place heap sort on finish, and best-first emission.
// ----------------------------------------------------------------------------
module tks_back
    import tks_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_max_targets,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_ready,
    tks_res_if.source        o_res
);

    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int LW = AW + 2;
    localparam int MW = 8;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_UP_RD   = 13'b0000000000010,
        S_UP_CMP  = 13'b0000000000100,
        S_REP_CMP = 13'b0000000001000,
        S_DN_L    = 13'b0000000010000,
        S_DN_R    = 13'b0000000100000,
        S_DN_C    = 13'b0000001000000,
        S_DN_M    = 13'b0000010000000,
        S_F_R1    = 13'b0000100000000,
        S_F_SW    = 13'b0001000000000,
        S_E_RD    = 13'b0010000000000,
        S_E_WT    = 13'b0100000000000,
        S_F_R0    = 13'b1000000000000
    } t_state;

    // heap memory
    t_rec    r_mem [MAX_KEEP];
    t_rec    r_rd;
    logic    mem_we;
    logic [AW-1:0] mem_wa, rd_addr;
    t_rec    mem_wd;

    t_state  r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_k, n_k;
    logic [AW-1:0] r_idx, n_idx, r_worst, n_worst;
    logic    r_fin, n_fin;
    t_rec    r_mov, n_mov, r_lrec, n_lrec, r_wrec, n_wrec, r_root, n_root;
    logic    r_ov, n_ov;
    t_rec    r_orec, n_orec;
    logic [4:0] r_rank, n_rank;
    logic    r_last, n_last, r_empty, n_empty;

    logic    out_free, dn_done;
    logic [MW-1:0] lim;
    logic [LW-1:0] lchild, rchild;
    logic [AW-1:0] parent;

    assign out_free = !r_ov || o_res.ready;
    assign o_q_ready = (r_state == S_IDLE) && out_free;

    // effective limit: zero acts as one, capped at depth
    always_comb begin
        lim = MW'(i_max_targets);
        if (lim == '0) lim = MW'(1);
        else if (lim > MW'(MAX_KEEP)) lim = MW'(MAX_KEEP);
    end

    assign lchild = {1'b0, r_idx, 1'b1};
    assign rchild = lchild + LW'(1);
    assign parent = AW'((LW'(r_idx) - LW'(1)) >> 1);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_n = r_n;  n_i = r_i;  n_k = r_k;
        n_idx = r_idx;  n_worst = r_worst;  n_fin = r_fin;
        n_mov = r_mov;  n_lrec = r_lrec;  n_wrec = r_wrec;  n_root = r_root;
        n_ov = r_ov && !o_res.ready;
        n_orec = r_orec;  n_rank = r_rank;  n_last = r_last;  n_empty = r_empty;
        mem_we = 1'b0;  mem_wa = r_idx;  mem_wd = r_mov;
        rd_addr = '0;
        dn_done = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && o_q_ready) begin
                    case (i_q_item.cmd)
                        CMD_CONSIDER: begin
                            n_mov = i_q_item.rec;
                            if (MW'(r_cnt) < lim) begin
                                n_idx   = AW'(r_cnt);
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end else begin
                                rd_addr = '0;
                                n_state = S_REP_CMP;
                            end
                        end
                        CMD_FINISH: begin
                            if (r_cnt == '0) begin
                                n_ov = 1'b1;  n_orec = '0;  n_rank = '0;
                                n_last = 1'b1;  n_empty = 1'b1;
                            end else begin
                                n_fin = 1'b1;  n_i = r_cnt;  n_k = '0;
                                if (r_cnt > CW'(1)) begin
                                    rd_addr = '0;
                                    n_state = S_F_R1;
                                end else begin
                                    n_state = S_E_RD;
                                end
                            end
                        end
                        CMD_CLEAR: n_cnt = '0;
                        default: ;
                    endcase
                end
            end
            // sift up with a hole at r_idx
            S_UP_RD: begin
                if (r_idx == '0) begin
                    mem_we = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (outranks(r_rd, r_mov)) begin
                    mem_wd  = r_rd;
                    n_idx   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // replace the root when the new record is better
            S_REP_CMP: begin
                if (outranks(r_mov, r_rd)) begin
                    n_idx = '0;  n_n = r_cnt;  n_fin = 1'b0;
                    n_state = S_DN_L;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // sift down with a hole at r_idx over r_n entries
            S_DN_L: begin
                if (lchild >= LW'(r_n)) begin
                    mem_we  = 1'b1;
                    dn_done = 1'b1;
                end else begin
                    rd_addr = lchild[AW-1:0];
                    n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                n_lrec = r_rd;
                if (rchild < LW'(r_n)) begin
                    rd_addr = rchild[AW-1:0];
                    n_state = S_DN_C;
                end else begin
                    n_wrec  = r_rd;
                    n_worst = lchild[AW-1:0];
                    n_state = S_DN_M;
                end
            end
            S_DN_C: begin
                if (outranks(r_lrec, r_rd)) begin
                    n_wrec = r_rd;    n_worst = rchild[AW-1:0];
                end else begin
                    n_wrec = r_lrec;  n_worst = lchild[AW-1:0];
                end
                n_state = S_DN_M;
            end
            S_DN_M: begin
                mem_we = 1'b1;
                if (outranks(r_mov, r_wrec)) begin
                    mem_wd  = r_wrec;
                    n_idx   = r_worst;
                    n_state = S_DN_L;
                end else begin
                    dn_done = 1'b1;
                end
            end
            // root read once the last sift-down write has landed
            S_F_R0: begin
                rd_addr = '0;
                n_state = S_F_R1;
            end
            // heap sort step: swap root with entry i-1, then sift down
            S_F_R1: begin
                n_root  = r_rd;
                rd_addr = AW'(r_i - CW'(1));
                n_state = S_F_SW;
            end
            S_F_SW: begin
                n_mov  = r_rd;
                mem_we = 1'b1;
                mem_wa = AW'(r_i - CW'(1));
                mem_wd = r_root;
                n_i    = r_i - CW'(1);
                n_n    = r_i - CW'(1);
                n_idx  = '0;
                n_state = S_DN_L;
            end
            // emission, best first
            S_E_RD: begin
                rd_addr = AW'(r_k);
                n_state = S_E_WT;
            end
            S_E_WT: begin
                if (out_free) begin
                    n_ov = 1'b1;  n_orec = r_rd;  n_rank = 5'(r_k);
                    n_empty = 1'b0;
                    n_last  = (r_k == r_cnt - CW'(1));
                    if (r_k == r_cnt - CW'(1)) begin
                        n_cnt   = '0;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_E_RD;
                    end
                end else begin
                    rd_addr = AW'(r_k);
                end
            end
            default: n_state = S_IDLE;
        endcase

        // end of a sift down: back to idle or on with the sort
        if (dn_done) begin
            if (r_fin) begin
                if (r_i > CW'(1)) begin
                    n_state = S_F_R0;
                end else begin
                    n_state = S_E_RD;
                end
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
            r_ov    <= n_ov;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n <= n_n;  r_i <= n_i;  r_k <= n_k;  r_idx <= n_idx;  r_worst <= n_worst;
        r_mov <= n_mov;  r_lrec <= n_lrec;  r_wrec <= n_wrec;  r_root <= n_root;
        r_orec <= n_orec;  r_rank <= n_rank;  r_last <= n_last;  r_empty <= n_empty;
    end

    assign o_res.valid          = r_ov;
    assign o_res.out_confidence = r_orec.conf;
    assign o_res.out_x          = r_orec.x;
    assign o_res.out_y          = r_orec.y;
    assign o_res.out_width      = r_orec.w;
    assign o_res.out_height     = r_orec.h;
    assign o_res.out_aim_x      = r_orec.ax;
    assign o_res.out_aim_y      = r_orec.ay;
    assign o_res.out_ident      = r_orec.id;
    assign o_res.rank           = r_rank;
    assign o_res.last           = r_last;
    assign o_res.empty_res      = r_empty;

endmodule

/* src/top_k_target_selector.sv */
// ----------------------------------------------------------------------------
// top_k_target_selector: keeps the best K target records and emits them sorted
// Item channel in (consider / finish / clear), result channel out, one
// max_targets register.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries commands: consider offers a record, finish emits all held
//   records best first (rank 0 up, last on the final one, or one empty-marked
//   result when none are held) and clears, clear empties the store silently.
//   o_res carries results; each transfer is one record.
//   Write max_targets through i_cfg_we / i_cfg_wdata only while idle.
// Timing:
//   Items go into a two-deep queue; the heap engine takes one at a time.
//   A consider sifts the new record up through the heap, or, when the store
//   is full and the record beats the root, replaces the root and sifts down.
//   A finish runs an in-place heap sort, then emits each held result. The
//   heap memory has a single read port, so sifts and sorts read one entry
//   at a time.
// Reset: empties the store and queue, max_targets returns to 32.
// A stalled receiver holds the result register; the engine waits, the
// queue keeps taking items until full.
// ----------------------------------------------------------------------------
module top_k_target_selector
    import tks_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    tks_item_if.sink         i_item,
    tks_res_if.source        o_res
);

    logic [CFG_W-1:0] r_max_targets;
    logic             q_valid, q_ready;
    t_item            q_item;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_targets <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_max_targets <= i_cfg_wdata;
        end
    end

    tks_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_ready (q_ready)
    );

    tks_back #(.MAX_KEEP(MAX_KEEP)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_targets (r_max_targets),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_ready     (q_ready),
        .o_res         (o_res)
    );

endmodule
